// File: hdl/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg: shared types and constants of the source token scanner
// Token kinds, scan modes, result records and the keyword lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

	// output field widths
	localparam int KIND_W = 5;
	localparam int OFF_W  = 20;
	localparam int LEN_W  = 20;
	localparam int LINE_W = 16;

	// result queue depth (holds two results of one byte plus slack)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// scan modes
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_WORD  = 3'd1;
	localparam logic [2:0] MODE_STR   = 3'd2;
	localparam logic [2:0] MODE_SLASH = 3'd3;
	localparam logic [2:0] MODE_NOTE  = 3'd4;
	localparam logic [2:0] MODE_BAR   = 3'd5;
	localparam logic [2:0] MODE_AMP   = 3'd6;
	localparam logic [2:0] MODE_BANG  = 3'd7;

	// token kinds
	localparam logic [KIND_W-1:0] K_IDENT    = 5'd0;
	localparam logic [KIND_W-1:0] K_NUMBER   = 5'd1;
	localparam logic [KIND_W-1:0] K_STRING   = 5'd2;
	localparam logic [KIND_W-1:0] K_KEYWORD0 = 5'd3;
	localparam logic [KIND_W-1:0] K_LPAREN   = 5'd10;
	localparam logic [KIND_W-1:0] K_RPAREN   = 5'd11;
	localparam logic [KIND_W-1:0] K_LBRACE   = 5'd12;
	localparam logic [KIND_W-1:0] K_RBRACE   = 5'd13;
	localparam logic [KIND_W-1:0] K_SEMI     = 5'd14;
	localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd15;
	localparam logic [KIND_W-1:0] K_LESS     = 5'd16;
	localparam logic [KIND_W-1:0] K_GREATER  = 5'd17;
	localparam logic [KIND_W-1:0] K_PLUS     = 5'd18;
	localparam logic [KIND_W-1:0] K_OR       = 5'd19;
	localparam logic [KIND_W-1:0] K_AND      = 5'd20;
	localparam logic [KIND_W-1:0] K_BANG     = 5'd21;
	localparam logic [KIND_W-1:0] K_BANG_EQ  = 5'd22;
	localparam logic [KIND_W-1:0] K_EOF      = 5'd23;
	localparam logic [KIND_W-1:0] K_BAD_CHAR = 5'd24;
	localparam logic [KIND_W-1:0] K_UNTERM   = 5'd25;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GREAT  = 8'h3E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// keyword spellings, first letter in element 0, zero padded
	localparam int PFX_N = 5;
	localparam int KW_N  = 7;
	localparam logic [0:PFX_N-1][7:0] KW_TEXT [KW_N] = '{
		"while",
		{"else", 8'h00},
		{"if", 24'h000000},
		{"var", 16'h0000},
		"print",
		{"true", 8'h00},
		"false"
	};
	localparam logic [2:0] KW_LEN [KW_N] = '{3'd5, 3'd4, 3'd2, 3'd3, 3'd5, 3'd4, 3'd5};

	// one result record
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [LINE_W-1:0] line;
		logic              last;
	} res_t;

	// up to two results of one byte, packed to the front
	typedef struct packed {
		logic v_first;
		logic v_second;
		res_t first;
		res_t second;
	} lex_out_t;

	// classify a finished letter run: keyword when the whole run matches
	function automatic logic [KIND_W-1:0] word_kind(
		input logic [0:PFX_N-1][7:0] pfx,
		input logic [2:0]            len
	);
		logic [KIND_W-1:0] k;
		logic              hit;
		k = K_IDENT;
		for (int w = KW_N - 1; w >= 0; w--) begin
			hit = (len == KW_LEN[w]);
			for (int i = 0; i < PFX_N; i++) begin
				if ((3'(i) < KW_LEN[w]) && (pfx[i] != KW_TEXT[w][i])) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				k = KIND_W'(K_KEYWORD0 + 5'(w));
			end
		end
		return k;
	endfunction

	// kind of a one-character operator, K_IDENT when the byte is none
	function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_SEMI:   k = K_SEMI;
			CH_EQUAL:  k = K_ASSIGN;
			CH_LESS:   k = K_LESS;
			CH_GREAT:  k = K_GREATER;
			CH_PLUS:   k = K_PLUS;
			default:   k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hdl/stsc_lexer.sv
// ----------------------------------------------------------------------------
// stsc_lexer: scanner state and per-byte token logic
// Holds the scan state and resolves one registered byte per step into up
// to two finished tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_lexer #(
	parameter int POS_BITS  = 20,
	parameter int LINE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        char_in,
	output stsc_pkg::lex_out_t     lex
);

	localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

	// scan state
	logic [2:0]                           mode_q, mode_d;
	logic [POS_BITS-1:0]                  pos_q, pos_d;
	logic [POS_BITS-1:0]                  begin_q, begin_d;
	logic [LINE_BITS-1:0]                 line_q, line_d;
	logic [0:stsc_pkg::PFX_N-1][7:0]      pfx_q, pfx_d;
	logic [2:0]                           ilen_q, ilen_d;
	logic                                 ended_q, ended_d;

	// raw results before width fitting
	logic                       v0, v1, rescan, is_letter;
	logic [stsc_pkg::KIND_W-1:0] k0, k1, op;
	logic [POS_BITS-1:0]        off0, len0, off1, len1, end_pos;
	logic [stsc_pkg::OFF_W+POS_BITS-1:0]   off0_x, len0_x, off1_x, len1_x;
	logic [stsc_pkg::LINE_W+LINE_BITS-1:0] line_x;
	stsc_pkg::res_t             r0, r1;

	assign is_letter = char_in inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	assign op        = stsc_pkg::single_op(char_in);
	assign end_pos   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

	// resolve a pending token, then rescan the byte from idle when it does not belong to that token
	always_comb begin
		mode_d  = mode_q;
		begin_d = begin_q;
		line_d  = line_q;
		pfx_d   = pfx_q;
		ilen_d  = ilen_q;
		ended_d = ended_q;
		pos_d   = end_pos;
		rescan  = 1'b0;
		v0      = 1'b0;
		v1      = 1'b0;
		k0      = stsc_pkg::K_IDENT;
		k1      = stsc_pkg::K_IDENT;
		off0    = begin_q;
		len0    = '0;
		off1    = pos_q;
		len1    = '0;

		case (mode_q)
			stsc_pkg::MODE_WORD: begin
				if (is_letter) begin
					if (ilen_q < 3'd5) begin
						pfx_d[ilen_q] = char_in;
					end
					if (ilen_q != 3'd7) begin
						ilen_d = ilen_q + 3'd1;
					end
				end else begin
					v0     = 1'b1;
					k0     = stsc_pkg::word_kind(pfx_q, ilen_q);
					len0   = pos_q - begin_q;
					mode_d = stsc_pkg::MODE_IDLE;
					rescan = 1'b1;
				end
			end
			stsc_pkg::MODE_STR: begin
				if (char_in == stsc_pkg::CH_QUOTE) begin
					v0     = 1'b1;
					k0     = stsc_pkg::K_STRING;
					len0   = end_pos - begin_q;
					mode_d = stsc_pkg::MODE_IDLE;
				end else if (char_in == stsc_pkg::CH_NUL) begin
					v0     = 1'b1;
					k0     = stsc_pkg::K_UNTERM;
					mode_d = stsc_pkg::MODE_IDLE;
					rescan = 1'b1;
				end else if (char_in == stsc_pkg::CH_LF) begin
					line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
				end
			end
			stsc_pkg::MODE_SLASH: begin
				if (char_in == stsc_pkg::CH_SLASH) begin
					mode_d = stsc_pkg::MODE_NOTE;
				end else begin
					v0     = 1'b1;
					k0     = stsc_pkg::K_BAD_CHAR;
					mode_d = stsc_pkg::MODE_IDLE;
					rescan = 1'b1;
				end
			end
			stsc_pkg::MODE_NOTE: begin
				if (char_in == stsc_pkg::CH_LF) begin
					line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
					mode_d = stsc_pkg::MODE_IDLE;
				end else if (char_in == stsc_pkg::CH_NUL) begin
					mode_d = stsc_pkg::MODE_IDLE;
					rescan = 1'b1;
				end
			end
			stsc_pkg::MODE_BAR, stsc_pkg::MODE_AMP: begin
				v0     = 1'b1;
				mode_d = stsc_pkg::MODE_IDLE;
				if ((mode_q == stsc_pkg::MODE_BAR && char_in == stsc_pkg::CH_BAR) ||
				    (mode_q == stsc_pkg::MODE_AMP && char_in == stsc_pkg::CH_AMP)) begin
					k0   = (mode_q == stsc_pkg::MODE_BAR) ? stsc_pkg::K_OR : stsc_pkg::K_AND;
					len0 = end_pos - begin_q;
				end else begin
					k0     = stsc_pkg::K_BAD_CHAR;
					rescan = 1'b1;
				end
			end
			stsc_pkg::MODE_BANG: begin
				v0     = 1'b1;
				mode_d = stsc_pkg::MODE_IDLE;
				if (char_in == stsc_pkg::CH_EQUAL) begin
					k0   = stsc_pkg::K_BANG_EQ;
					len0 = end_pos - begin_q;
				end else begin
					k0     = stsc_pkg::K_BANG;
					len0   = pos_q - begin_q;
					rescan = 1'b1;
				end
			end
			default: begin
				mode_d = stsc_pkg::MODE_IDLE;
				rescan = 1'b1;
			end
		endcase

		// fresh scan of the byte with no token pending
		if (rescan) begin
			if (char_in == stsc_pkg::CH_NUL) begin
				v1      = 1'b1;
				k1      = stsc_pkg::K_EOF;
				ended_d = 1'b1;
			end else if (char_in == stsc_pkg::CH_SPACE || char_in == stsc_pkg::CH_CR ||
			             char_in == stsc_pkg::CH_TAB) begin
				v1 = 1'b0;
			end else if (char_in == stsc_pkg::CH_LF) begin
				line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
			end else if (is_letter) begin
				begin_d  = pos_q;
				mode_d   = stsc_pkg::MODE_WORD;
				pfx_d[0] = char_in;
				ilen_d   = 3'd1;
			end else if (char_in inside {[8'h30:8'h39]}) begin
				v1   = 1'b1;
				k1   = stsc_pkg::K_NUMBER;
				len1 = end_pos - pos_q;
			end else if (op != stsc_pkg::K_IDENT) begin
				v1   = 1'b1;
				k1   = op;
				len1 = end_pos - pos_q;
			end else if (char_in == stsc_pkg::CH_QUOTE) begin
				begin_d = pos_q;
				mode_d  = stsc_pkg::MODE_STR;
			end else if (char_in == stsc_pkg::CH_SLASH) begin
				begin_d = pos_q;
				mode_d  = stsc_pkg::MODE_SLASH;
			end else if (char_in == stsc_pkg::CH_BAR) begin
				begin_d = pos_q;
				mode_d  = stsc_pkg::MODE_BAR;
			end else if (char_in == stsc_pkg::CH_AMP) begin
				begin_d = pos_q;
				mode_d  = stsc_pkg::MODE_AMP;
			end else if (char_in == stsc_pkg::CH_BANG) begin
				begin_d = pos_q;
				mode_d  = stsc_pkg::MODE_BANG;
			end else begin
				v1 = 1'b1;
				k1 = stsc_pkg::K_BAD_CHAR;
			end
		end
	end

	// fit positions and line count to the output field widths
	assign off0_x = {{stsc_pkg::OFF_W{1'b0}}, off0};
	assign len0_x = {{stsc_pkg::OFF_W{1'b0}}, len0};
	assign off1_x = {{stsc_pkg::OFF_W{1'b0}}, off1};
	assign len1_x = {{stsc_pkg::OFF_W{1'b0}}, len1};
	assign line_x = {{stsc_pkg::LINE_W{1'b0}}, line_q};

	always_comb begin
		r0.kind   = k0;
		r0.offset = off0_x[stsc_pkg::OFF_W-1:0];
		r0.length = len0_x[stsc_pkg::LEN_W-1:0];
		r0.line   = line_x[stsc_pkg::LINE_W-1:0];
		r0.last   = !v1;
		r1.kind   = k1;
		r1.offset = off1_x[stsc_pkg::OFF_W-1:0];
		r1.length = len1_x[stsc_pkg::LEN_W-1:0];
		r1.line   = line_x[stsc_pkg::LINE_W-1:0];
		r1.last   = 1'b1;
	end

	// pack the results to the front; nothing once the source has ended
	always_comb begin
		lex.v_first  = step && !ended_q && (v0 || v1);
		lex.v_second = step && !ended_q && v0 && v1;
		lex.first    = v0 ? r0 : r1;
		lex.second   = r1;
	end

	// advance the scan state on each byte before end of source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stsc_pkg::MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
			ilen_q  <= 3'd0;
			ended_q <= 1'b0;
		end else if (step && !ended_q) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			begin_q <= begin_d;
			line_q  <= line_d;
			ilen_q  <= ilen_d;
			ended_q <= ended_d;
		end
	end

	// letter-run prefix is payload only
	always_ff @(posedge clk) begin
		if (step && !ended_q) begin
			pfx_q <= pfx_d;
		end
	end

	// no token once the source has ended
	assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !lex.v_first)
		else $error("token produced after end of source");

	// the line count never drops to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count reached zero");

	// end of source freezes the read position
	assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> $stable(pos_q))
		else $error("read position moved after end of source");

endmodule

`default_nettype wire

// File: hdl/stsc_res_queue.sv
// ----------------------------------------------------------------------------
// stsc_res_queue: result queue of the source token scanner
// Small register queue that takes up to two results per cycle and hands
// out one per transfer on the token channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_res_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire stsc_pkg::lex_out_t  lex,
	output logic                     room,
	output logic                     tok_valid,
	input  wire logic                tok_ready,
	output stsc_pkg::res_t           head
);

	stsc_pkg::res_t                  mem_q [stsc_pkg::QDEPTH];
	logic [stsc_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [stsc_pkg::QCNT_W-1:0]     count_q;
	logic                            pop;
	logic [stsc_pkg::QCNT_W-1:0]     push_n;

	assign tok_valid = (count_q != '0);
	assign head      = mem_q[rd_q];
	assign pop       = tok_valid && tok_ready;
	assign push_n    = {{(stsc_pkg::QCNT_W-1){1'b0}}, lex.v_first} +
	                   {{(stsc_pkg::QCNT_W-1){1'b0}}, lex.v_second};

	// room for a full pair of results, counting a transfer this cycle
	assign room = (count_q <= stsc_pkg::QCNT_W'(stsc_pkg::QDEPTH - 2)) ||
	              ((count_q == stsc_pkg::QCNT_W'(stsc_pkg::QDEPTH - 1)) && pop);

	// write incoming results in order
	always_ff @(posedge clk) begin
		if (lex.v_first) begin
			mem_q[wr_q] <= lex.first;
		end
		if (lex.v_second) begin
			mem_q[wr_q + 1'b1] <= lex.second;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_n[stsc_pkg::QPTR_W-1:0];
			rd_q    <= rd_q + {{(stsc_pkg::QPTR_W-1){1'b0}}, pop};
			count_q <= count_q + push_n - {{(stsc_pkg::QCNT_W-1){1'b0}}, pop};
		end
	end

	// occupancy stays within the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= stsc_pkg::QCNT_W'(stsc_pkg::QDEPTH))
		else $error("result queue overflow");

	// a second result only comes with a first
	assert property (@(posedge clk) disable iff (!arst_n)
		lex.v_second |-> lex.v_first)
		else $error("second result without first");

	// hold a waiting token steady until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(head))
		else $error("waiting token changed");

endmodule

`default_nettype wire

// File: hdl/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexer top level
// Takes one source byte per transfer and returns finished tokens.
// ----------------------------------------------------------------------------
// Source channel: char_code with src_valid / src_ready; byte 0 ends the
// source, and every byte after it is taken and dropped until reset.
// Token channel: token_kind, token_offset, token_length, token_line and
// last_of_run with tok_valid / tok_ready; last_of_run marks the final
// token caused by one source byte.
// Path: a token passes the input register and then the result queue before
// it is offered on the token channel.
// Throughput: one byte per cycle while the result queue has room; a byte that
// closes a pending token and starts another yields two tokens, and the token
// channel moves one per cycle, so the token channel sets the sustained rate.
// Reset: clears the scan state, read position 0, line count 1, queue empty.
// Stall: while tok_ready is low the four-entry result queue fills; once it
// cannot take two more results the input register holds its byte and
// src_ready drops. No token is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_scanner #(
	parameter int POS_BITS  = 20,
	parameter int LINE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          src_valid,
	output logic                               src_ready,
	input  wire logic [7:0]                    char_code,
	output logic                               tok_valid,
	input  wire logic                          tok_ready,
	output logic [stsc_pkg::KIND_W-1:0]        token_kind,
	output logic [stsc_pkg::OFF_W-1:0]         token_offset,
	output logic [stsc_pkg::LEN_W-1:0]         token_length,
	output logic [stsc_pkg::LINE_W-1:0]        token_line,
	output logic                               last_of_run
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               step;
	logic               room;
	stsc_pkg::lex_out_t lex;
	stsc_pkg::res_t     head;

	// process the registered byte when the queue can take its results
	assign step      = valid_s1 && room;
	assign src_ready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			char_s1 <= char_code;
		end
	end

	stsc_lexer #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (char_s1),
		.lex     (lex)
	);

	stsc_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.lex       (lex),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign last_of_run  = head.last;

endmodule

`default_nettype wire

// File: sim/source_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// source_token_scanner_tb: self-checking bench for the streaming lexer
// Feeds one source stream through the scanner: a short table of directed
// bytes, then random token fragments with noise, a run of newlines, and an
// end of source followed by bytes that must be dropped. A byte-level model
// of the scanner predicts the tokens of most bytes, the rest are typed into
// the table, and each token transfer is checked against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module source_token_scanner_tb;

	localparam int POS_BITS  = 20;
	localparam int LINE_BITS = 16;

	localparam int RAND_ITEMS   = 1800;
	localparam int IDLE_BLOCK   = 150;
	localparam int HOLD_AT      = 900;
	localparam int HOLD_CYCLES  = 300;
	localparam int LF_RUN       = 40;
	localparam int DRAIN_CYCLES = 6;
	localparam int TIMEOUT_NS   = 10_000_000;
	localparam int MAX_REPORTS  = 10;

	// keyword kinds, in spelling order
	localparam logic [stsc_pkg::KIND_W-1:0] K_WHILE = stsc_pkg::K_KEYWORD0 + 5'd0;
	localparam logic [stsc_pkg::KIND_W-1:0] K_ELSE  = stsc_pkg::K_KEYWORD0 + 5'd1;
	localparam logic [stsc_pkg::KIND_W-1:0] K_IF    = stsc_pkg::K_KEYWORD0 + 5'd2;
	localparam logic [stsc_pkg::KIND_W-1:0] K_VAR   = stsc_pkg::K_KEYWORD0 + 5'd3;
	localparam logic [stsc_pkg::KIND_W-1:0] K_PRINT = stsc_pkg::K_KEYWORD0 + 5'd4;
	localparam logic [stsc_pkg::KIND_W-1:0] K_TRUE  = stsc_pkg::K_KEYWORD0 + 5'd5;
	localparam logic [stsc_pkg::KIND_W-1:0] K_FALSE = stsc_pkg::K_KEYWORD0 + 5'd6;

	typedef struct packed {
		logic [stsc_pkg::KIND_W-1:0] kind;
		logic [stsc_pkg::OFF_W-1:0]  offset;
		logic [stsc_pkg::LEN_W-1:0]  length;
		logic [stsc_pkg::LINE_W-1:0] line;
		logic                        last;
	} tok_t;

	// one directed byte: token count typed in, or ROW_PRED for the model
	typedef struct packed {
		logic [7:0] c;
		logic [1:0] n;
		tok_t       e0;
		tok_t       e1;
	} row_t;

	localparam logic [1:0] ROW_PRED = 2'd3;
	localparam tok_t       NO_TOK   = '0;
	localparam int         DIR_N    = 26;

	logic                          clk;
	logic                          arst_n;
	logic                          src_valid;
	logic                          src_ready;
	logic [7:0]                    char_code;
	logic                          tok_valid;
	logic                          tok_ready;
	logic [stsc_pkg::KIND_W-1:0]   token_kind;
	logic [stsc_pkg::OFF_W-1:0]    token_offset;
	logic [stsc_pkg::LEN_W-1:0]    token_length;
	logic [stsc_pkg::LINE_W-1:0]   token_line;
	logic                          last_of_run;

	// scanner model state
	logic [2:0]           sc_mode;
	logic [POS_BITS-1:0]  sc_pos;
	logic [POS_BITS-1:0]  sc_begin;
	logic [LINE_BITS-1:0] sc_line;
	logic [7:0]           sc_pfx [5];
	logic [2:0]           sc_wlen;
	logic                 sc_ended;
	tok_t                 scan_out [2];
	int                   scan_n;

	tok_t tokens_due [$];
	row_t dir_tab [DIR_N];
	int   err_cnt;
	int   bytes_sent;
	int   hold_req;
	int   hold_done;
	bit   src_idle_en;
	bit   sink_idle_en;

	string kw_words [7] = '{"while", "else", "if", "var", "print", "true", "false"};
	string op_words [16] = '{"(", ")", "{", "}", ";", "=", "<", ">", "+",
		"!", "!=", "||", "&&", "|", "&", "/"};
	string near_kw = "whileseprintvarfuWE";

	source_token_scanner #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.char_code    (char_code),
		.tok_valid    (tok_valid),
		.tok_ready    (tok_ready),
		.token_kind   (token_kind),
		.token_offset (token_offset),
		.token_length (token_length),
		.token_line   (token_line),
		.last_of_run  (last_of_run)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic tok_t tk(
		input logic [stsc_pkg::KIND_W-1:0] kind,
		input logic [stsc_pkg::OFF_W-1:0]  off,
		input logic [stsc_pkg::LEN_W-1:0]  len,
		input logic [stsc_pkg::LINE_W-1:0] line,
		input logic                        last
	);
		tok_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = len;
		t.line   = line;
		t.last   = last;
		return t;
	endfunction

	function automatic row_t mk(input logic [7:0] c, input logic [1:0] n,
		input tok_t e0, input tok_t e1);
		row_t r;
		r.c  = c;
		r.n  = n;
		r.e0 = e0;
		r.e1 = e1;
		return r;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// append one token to the results of the current byte
	task automatic put_tok(input logic [stsc_pkg::KIND_W-1:0] kind,
		input logic [POS_BITS-1:0] off, input logic [POS_BITS-1:0] len);
		scan_out[scan_n] = tk(kind, off, len, sc_line, 1'b0);
		scan_n++;
	endtask

	// advance the scanner model by one byte, leaving its tokens in scan_out
	task automatic scan_byte(input logic [7:0] c);
		logic [POS_BITS-1:0]         pos;
		logic [POS_BITS-1:0]         nxt;
		logic [39:0]                 w;
		logic [stsc_pkg::KIND_W-1:0] wk;
		logic                        rescan;
		scan_n = 0;
		if (!sc_ended) begin
			pos    = sc_pos;
			nxt    = (pos != {POS_BITS{1'b1}}) ? pos + 1'b1 : pos;
			rescan = 1'b0;
			case (sc_mode)
				stsc_pkg::MODE_WORD: begin
					if (is_letter(c)) begin
						if (sc_wlen < 3'd5) sc_pfx[sc_wlen] = c;
						if (sc_wlen < 3'd7) sc_wlen++;
					end else begin
						// keyword only when the whole run spells it
						w  = {sc_pfx[0], sc_pfx[1], sc_pfx[2], sc_pfx[3], sc_pfx[4]};
						wk = stsc_pkg::K_IDENT;
						case (sc_wlen)
							3'd2: if (w[39:24] == "if") wk = K_IF;
							3'd3: if (w[39:16] == "var") wk = K_VAR;
							3'd4: begin
								if (w[39:8] == "else") wk = K_ELSE;
								else if (w[39:8] == "true") wk = K_TRUE;
							end
							3'd5: begin
								if (w == "while") wk = K_WHILE;
								else if (w == "print") wk = K_PRINT;
								else if (w == "false") wk = K_FALSE;
							end
							default: wk = stsc_pkg::K_IDENT;
						endcase
						put_tok(wk, sc_begin, pos - sc_begin);
						rescan = 1'b1;
					end
				end
				stsc_pkg::MODE_STR: begin
					if (c == stsc_pkg::CH_QUOTE) begin
						put_tok(stsc_pkg::K_STRING, sc_begin, nxt - sc_begin);
						sc_mode = stsc_pkg::MODE_IDLE;
					end else if (c == stsc_pkg::CH_NUL) begin
						put_tok(stsc_pkg::K_UNTERM, sc_begin, '0);
						rescan = 1'b1;
					end else if (c == stsc_pkg::CH_LF) begin
						if (sc_line != '1) sc_line++;
					end
				end
				stsc_pkg::MODE_SLASH: begin
					if (c == stsc_pkg::CH_SLASH) begin
						sc_mode = stsc_pkg::MODE_NOTE;
					end else begin
						put_tok(stsc_pkg::K_BAD_CHAR, sc_begin, '0);
						rescan = 1'b1;
					end
				end
				stsc_pkg::MODE_NOTE: begin
					if (c == stsc_pkg::CH_LF) begin
						if (sc_line != '1) sc_line++;
						sc_mode = stsc_pkg::MODE_IDLE;
					end else if (c == stsc_pkg::CH_NUL) begin
						rescan = 1'b1;
					end
				end
				stsc_pkg::MODE_BAR: begin
					if (c == stsc_pkg::CH_BAR) begin
						put_tok(stsc_pkg::K_OR, sc_begin, nxt - sc_begin);
						sc_mode = stsc_pkg::MODE_IDLE;
					end else begin
						put_tok(stsc_pkg::K_BAD_CHAR, sc_begin, '0);
						rescan = 1'b1;
					end
				end
				stsc_pkg::MODE_AMP: begin
					if (c == stsc_pkg::CH_AMP) begin
						put_tok(stsc_pkg::K_AND, sc_begin, nxt - sc_begin);
						sc_mode = stsc_pkg::MODE_IDLE;
					end else begin
						put_tok(stsc_pkg::K_BAD_CHAR, sc_begin, '0);
						rescan = 1'b1;
					end
				end
				stsc_pkg::MODE_BANG: begin
					if (c == stsc_pkg::CH_EQUAL) begin
						put_tok(stsc_pkg::K_BANG_EQ, sc_begin, nxt - sc_begin);
						sc_mode = stsc_pkg::MODE_IDLE;
					end else begin
						put_tok(stsc_pkg::K_BANG, sc_begin, pos - sc_begin);
						rescan = 1'b1;
					end
				end
				default: rescan = 1'b1;
			endcase

			// scan the byte with nothing pending
			if (rescan) begin
				sc_mode = stsc_pkg::MODE_IDLE;
				case (c)
					stsc_pkg::CH_NUL: begin
						put_tok(stsc_pkg::K_EOF, pos, '0);
						sc_ended = 1'b1;
					end
					stsc_pkg::CH_SPACE, stsc_pkg::CH_CR, stsc_pkg::CH_TAB: ;
					stsc_pkg::CH_LF:     if (sc_line != '1) sc_line++;
					stsc_pkg::CH_LPAREN: put_tok(stsc_pkg::K_LPAREN, pos, nxt - pos);
					stsc_pkg::CH_RPAREN: put_tok(stsc_pkg::K_RPAREN, pos, nxt - pos);
					stsc_pkg::CH_LBRACE: put_tok(stsc_pkg::K_LBRACE, pos, nxt - pos);
					stsc_pkg::CH_RBRACE: put_tok(stsc_pkg::K_RBRACE, pos, nxt - pos);
					stsc_pkg::CH_SEMI:   put_tok(stsc_pkg::K_SEMI, pos, nxt - pos);
					stsc_pkg::CH_EQUAL:  put_tok(stsc_pkg::K_ASSIGN, pos, nxt - pos);
					stsc_pkg::CH_LESS:   put_tok(stsc_pkg::K_LESS, pos, nxt - pos);
					stsc_pkg::CH_GREAT:  put_tok(stsc_pkg::K_GREATER, pos, nxt - pos);
					stsc_pkg::CH_PLUS:   put_tok(stsc_pkg::K_PLUS, pos, nxt - pos);
					stsc_pkg::CH_QUOTE: begin
						sc_begin = pos;
						sc_mode  = stsc_pkg::MODE_STR;
					end
					stsc_pkg::CH_SLASH: begin
						sc_begin = pos;
						sc_mode  = stsc_pkg::MODE_SLASH;
					end
					stsc_pkg::CH_BAR: begin
						sc_begin = pos;
						sc_mode  = stsc_pkg::MODE_BAR;
					end
					stsc_pkg::CH_AMP: begin
						sc_begin = pos;
						sc_mode  = stsc_pkg::MODE_AMP;
					end
					stsc_pkg::CH_BANG: begin
						sc_begin = pos;
						sc_mode  = stsc_pkg::MODE_BANG;
					end
					default: begin
						if (is_letter(c)) begin
							sc_begin  = pos;
							sc_mode   = stsc_pkg::MODE_WORD;
							sc_pfx[0] = c;
							sc_wlen   = 3'd1;
						end else if (c >= "0" && c <= "9") begin
							put_tok(stsc_pkg::K_NUMBER, pos, nxt - pos);
						end else begin
							put_tok(stsc_pkg::K_BAD_CHAR, pos, '0);
						end
					end
				endcase
			end

			sc_pos = nxt;
			if (scan_n > 0) scan_out[scan_n-1].last = 1'b1;
		end
	endtask

	// offer one byte, hold it until the transfer, then queue its tokens
	task automatic send_byte(input row_t r);
		int gap;
		int i;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			src_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_code = r.c;
		src_valid = 1'b1;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		scan_byte(r.c);
		if (r.n == ROW_PRED) begin
			for (i = 0; i < scan_n; i++) tokens_due.push_back(scan_out[i]);
		end else begin
			if (r.n > 2'd0) tokens_due.push_back(r.e0);
			if (r.n > 2'd1) tokens_due.push_back(r.e1);
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_char(input logic [7:0] c);
		send_byte(mk(c, ROW_PRED, NO_TOK, NO_TOK));
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// one random piece of source, mostly well formed
	task automatic send_fragment();
		int         sel;
		int         n;
		int         i;
		logic [7:0] b;
		sel = $urandom_range(0, 19);
		case (sel)
			0, 1, 2: send_text(kw_words[$urandom_range(0, 6)]);
			3, 4: begin
				n = $urandom_range(1, 9);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 1) == 0) begin
						b = near_kw[$urandom_range(0, near_kw.len() - 1)];
					end else if ($urandom_range(0, 1) == 0) begin
						b = 8'("a" + $urandom_range(0, 25));
					end else begin
						b = 8'("A" + $urandom_range(0, 25));
					end
					send_char(b);
				end
			end
			5: send_char(8'("0" + $urandom_range(0, 9)));
			6, 7, 8, 9: send_text(op_words[$urandom_range(0, 15)]);
			13: begin
				// string with random content, sometimes across lines
				send_char(stsc_pkg::CH_QUOTE);
				n = $urandom_range(0, 8);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						b = stsc_pkg::CH_LF;
					end else begin
						do b = 8'($urandom_range(1, 255)); while (b == stsc_pkg::CH_QUOTE);
					end
					send_char(b);
				end
				send_char(stsc_pkg::CH_QUOTE);
			end
			14: begin
				send_text("//");
				n = $urandom_range(0, 8);
				for (i = 0; i < n; i++) begin
					do b = 8'($urandom_range(1, 255)); while (b == stsc_pkg::CH_LF);
					send_char(b);
				end
				send_char(stsc_pkg::CH_LF);
			end
			15: send_char(8'($urandom_range(1, 255)));
			default: begin
				case ($urandom_range(0, 3))
					0: send_char(stsc_pkg::CH_SPACE);
					1: send_char(stsc_pkg::CH_TAB);
					2: send_char(stsc_pkg::CH_CR);
					default: send_char(stsc_pkg::CH_LF);
				endcase
			end
		endcase
	endtask

	// token sink: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		tok_ready = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				hold_done++;
				tok_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				tok_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			tok_ready = 1'b1;
		end
	end

	// check each token transfer against the oldest prediction
	always @(posedge clk) begin
		tok_t exp_t;
		if (arst_n && tok_valid && tok_ready) begin
			if (tokens_due.size() == 0) begin
				if (err_cnt < MAX_REPORTS) begin
					$display("unexpected token: kind %0d off %0d len %0d line %0d last %0d",
						token_kind, token_offset, token_length, token_line, last_of_run);
				end
				err_cnt++;
			end else begin
				exp_t = tokens_due.pop_front();
				if (token_kind !== exp_t.kind || token_offset !== exp_t.offset ||
					token_length !== exp_t.length || token_line !== exp_t.line ||
					last_of_run !== exp_t.last) begin
					if (err_cnt < MAX_REPORTS) begin
						$display("token mismatch: exp kind %0d off %0d len %0d line %0d last %0d",
							exp_t.kind, exp_t.offset, exp_t.length, exp_t.line, exp_t.last);
						$display("                got kind %0d off %0d len %0d line %0d last %0d",
							token_kind, token_offset, token_length, token_line, last_of_run);
					end
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

	// stimulus
	initial begin
		int next_mode_at;
		bit hold_sent;
		arst_n       = 1'b0;
		src_valid    = 1'b0;
		char_code    = stsc_pkg::CH_NUL;
		err_cnt      = 0;
		bytes_sent   = 0;
		hold_req     = 0;
		hold_sent    = 1'b0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		sc_mode      = stsc_pkg::MODE_IDLE;
		sc_pos       = '0;
		sc_begin     = '0;
		sc_line      = 1;
		sc_wlen      = '0;
		sc_ended     = 1'b0;
		foreach (sc_pfx[i]) sc_pfx[i] = '0;

		// directed bytes: operators, extremes, pending tokens, comment, string
		dir_tab = '{
			mk("(", 2'd1, tk(stsc_pkg::K_LPAREN, 0, 1, 1, 1'b1), NO_TOK),
			mk(8'hFF, 2'd1, tk(stsc_pkg::K_BAD_CHAR, 1, 0, 1, 1'b1), NO_TOK),
			mk("7", 2'd1, tk(stsc_pkg::K_NUMBER, 2, 1, 1, 1'b1), NO_TOK),
			mk("w", ROW_PRED, NO_TOK, NO_TOK),
			mk("h", ROW_PRED, NO_TOK, NO_TOK),
			mk("i", ROW_PRED, NO_TOK, NO_TOK),
			mk("l", ROW_PRED, NO_TOK, NO_TOK),
			mk("e", ROW_PRED, NO_TOK, NO_TOK),
			mk(stsc_pkg::CH_SPACE, ROW_PRED, NO_TOK, NO_TOK),
			mk("!", ROW_PRED, NO_TOK, NO_TOK),
			mk("=", ROW_PRED, NO_TOK, NO_TOK),
			mk("!", ROW_PRED, NO_TOK, NO_TOK),
			mk("x", ROW_PRED, NO_TOK, NO_TOK),
			mk("|", ROW_PRED, NO_TOK, NO_TOK),
			mk("|", ROW_PRED, NO_TOK, NO_TOK),
			mk("&", ROW_PRED, NO_TOK, NO_TOK),
			mk("a", 2'd1, tk(stsc_pkg::K_BAD_CHAR, 15, 0, 1, 1'b1), NO_TOK),
			mk("/", ROW_PRED, NO_TOK, NO_TOK),
			mk("/", ROW_PRED, NO_TOK, NO_TOK),
			mk(8'h80, ROW_PRED, NO_TOK, NO_TOK),
			mk(stsc_pkg::CH_LF, ROW_PRED, NO_TOK, NO_TOK),
			mk(stsc_pkg::CH_QUOTE, ROW_PRED, NO_TOK, NO_TOK),
			mk(stsc_pkg::CH_LF, ROW_PRED, NO_TOK, NO_TOK),
			mk(stsc_pkg::CH_QUOTE, ROW_PRED, NO_TOK, NO_TOK),
			mk("/", ROW_PRED, NO_TOK, NO_TOK),
			mk(";", 2'd2, tk(stsc_pkg::K_BAD_CHAR, 24, 0, 3, 1'b0),
				tk(stsc_pkg::K_SEMI, 25, 1, 3, 1'b1))
		};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_byte(dir_tab[i]);

		// random fragments, idling pattern changes block by block
		next_mode_at = bytes_sent;
		while (bytes_sent < RAND_ITEMS) begin
			if (bytes_sent >= next_mode_at) begin
				case ($urandom_range(0, 3))
					0: begin src_idle_en = 1'b1; sink_idle_en = 1'b1; end
					1: begin src_idle_en = 1'b1; sink_idle_en = 1'b0; end
					2: begin src_idle_en = 1'b0; sink_idle_en = 1'b1; end
					default: begin src_idle_en = 1'b0; sink_idle_en = 1'b0; end
				endcase
				next_mode_at = bytes_sent + IDLE_BLOCK;
			end
			if (!hold_sent && bytes_sent >= HOLD_AT) begin
				hold_req++;
				hold_sent = 1'b1;
			end
			send_fragment();
		end

		// last part at full rate: a run of newlines, then end the source
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (LF_RUN) send_char(stsc_pkg::CH_LF);
		send_text("x;\"a\nb\" ");
		case ($urandom_range(0, 5))
			0: send_text(";");
			1: send_text("\"ab\ncd");
			2: send_text("// open");
			3: send_text("var");
			4: send_text("|");
			default: send_text("!");
		endcase
		send_char(stsc_pkg::CH_NUL);

		// bytes after the end of source are dropped
		repeat (20) send_char(8'($urandom_range(0, 255)));
		src_valid = 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
